// ===== rtl/core/page_frame_bitmap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Page frame bitmap allocator assertion macros
// Shared forms for concurrent checks clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Transaction types, request and status codes and configuration indexes.
// ----------------------------------------------------------------------------
package pfba_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BITMAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KERNEL = 1'b1;

    localparam logic [CFG_W-1:0] BITMAP_BYTES_RST = 13'd4096;
    localparam logic [CFG_W-1:0] KERNEL_BYTES_RST = 13'd96;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_RESERVE = 2'd2;
    localparam logic [1:0] REQ_COUNT   = 2'd3;

    localparam logic ZONE_KERNEL = 1'b0;
    localparam logic ZONE_USER   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        zone;
        logic [31:0] frame_addr;
        logic [14:0] frame_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_addr;
        logic [15:0] free_count;
    } t_rsp;

endpackage

// ===== rtl/core/pfba_ram.sv =====
// ----------------------------------------------------------------------------
// Bitmap RAM
// Single write port, single read port byte memory with registered read data.
// ----------------------------------------------------------------------------
module pfba_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/pfba_engine.sv =====
// ----------------------------------------------------------------------------
// Bitmap engine
// Clears the bitmap after reset, scans zones one byte per cycle for alloc and
// count, and does read-modify-write of single bits for free and reserve.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_macros.svh"

module pfba_engine #(
    parameter int          MAX_BITMAP_BYTES = 4096,
    parameter int          PAGE_SHIFT       = 12,
    parameter logic [31:0] FRAME_BASE       = 32'h0010_0000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pfba_pkg::t_req                i_req,
    input  logic [pfba_pkg::CFG_W-1:0]    i_eff_bytes,
    input  logic [pfba_pkg::CFG_W-1:0]    i_split,
    input  logic                          i_res_ready,
    output logic                          o_idle,
    output logic                          o_done,
    output pfba_pkg::t_rsp                o_rsp
);
    import pfba_pkg::*;

    localparam int AW = (MAX_BITMAP_BYTES > 1) ? $clog2(MAX_BITMAP_BYTES) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BITMAP_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RD,
        S_WR,
        S_DONE
    } t_state;

    function automatic logic [3:0] zero_count(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'b000, ~b[k]};
        end
        return n;
    endfunction

    function automatic logic [2:0] first_clear(input logic [7:0] b);
        logic [2:0] pos;
        pos = '0;
        for (int k = 0; k < 8; k++) begin
            if (!b[k]) begin
                pos = 3'(7 - k);
            end
        end
        return pos;
    endfunction

    t_state            r_state;
    logic [AW-1:0]     r_clr_ptr;
    logic [1:0]        r_op;
    logic [CFG_W-1:0]  r_issue;
    logic [CFG_W-1:0]  r_hi;
    logic              r_rd_vld;
    logic [CFG_W-1:0]  r_rd_ptr;
    logic [CFG_W-1:0]  r_byte;
    logic [2:0]        r_bit;
    logic [16:0]       r_acc;
    t_rsp              r_rsp;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              hit;
    logic [2:0]        alloc_bit;
    logic [7:0]        alloc_mask;
    logic [7:0]        rmw_mask;
    logic [31:0]       alloc_addr;

    logic [15:0]       nbits;
    logic [CFG_W-1:0]  lo;
    logic [CFG_W-1:0]  hi;
    logic [31:0]       addr_off;
    logic [31:0]       addr_idx;
    logic              free_bad;
    logic              rsv_bad;
    logic [15:0]       tgt_idx;
    logic [15:0]       sat_count;

    pfba_ram #(
        .DEPTH (MAX_BITMAP_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        nbits    = {i_eff_bytes, 3'b000};
        addr_off = i_req.frame_addr - FRAME_BASE;
        addr_idx = addr_off >> PAGE_SHIFT;
        free_bad = (i_req.frame_addr < FRAME_BASE) || (addr_idx >= 32'(nbits));
        rsv_bad  = ({1'b0, i_req.frame_index} >= nbits);
        tgt_idx  = (i_req.req_type == REQ_FREE) ? addr_idx[15:0]
                                                : {1'b0, i_req.frame_index};
        if (i_req.zone == ZONE_KERNEL) begin
            lo = '0;
            hi = i_split;
        end else begin
            lo = i_split;
            hi = i_eff_bytes;
        end
        sat_count = (r_acc > 17'h0FFFF) ? 16'hFFFF : r_acc[15:0];
    end

    always_comb begin
        alloc_bit  = first_clear(rd_data);
        alloc_mask = 8'h80 >> alloc_bit;
        rmw_mask   = 8'h80 >> r_bit;
        alloc_addr = FRAME_BASE + (32'({r_rd_ptr, alloc_bit}) << PAGE_SHIFT);
        hit        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = AW'(r_issue);
        wr_en      = 1'b0;
        wr_addr    = AW'(r_rd_ptr);
        wr_data    = rd_data | alloc_mask;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_ptr;
                wr_data = '0;
            end
            S_SCAN: begin
                hit   = r_rd_vld && (r_op == REQ_ALLOC) && (rd_data != 8'hFF);
                rd_en = (r_issue < r_hi) && !hit;
                wr_en = hit;
            end
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_byte);
            end
            S_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_byte);
                wr_data = (r_op == REQ_FREE) ? (rd_data & ~rmw_mask) : (rd_data | rmw_mask);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_ptr <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            r_rd_ptr <= r_issue;
            if (rd_en && (r_state == S_SCAN)) begin
                r_issue <= r_issue + CFG_W'(1);
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + AW'(1);
                    if (r_clr_ptr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op <= i_req.req_type;
                        unique case (i_req.req_type) inside
                            REQ_ALLOC, REQ_COUNT: begin
                                r_issue <= lo;
                                r_hi    <= hi;
                                r_acc   <= '0;
                                if (lo >= hi) begin
                                    r_rsp   <= '{status: (i_req.req_type == REQ_ALLOC)
                                                         ? ST_NONE : ST_OK,
                                                 alloc_addr: '0, free_count: '0};
                                    r_state <= S_DONE;
                                end else begin
                                    r_rsp   <= '{status: ST_OK, alloc_addr: '0,
                                                 free_count: '0};
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_FREE, REQ_RESERVE: begin
                                r_byte <= tgt_idx[15:3];
                                r_bit  <= tgt_idx[2:0];
                                if ((i_req.req_type == REQ_FREE) ? free_bad : rsv_bad) begin
                                    r_rsp   <= '{status: ST_RANGE, alloc_addr: '0,
                                                 free_count: '0};
                                    r_state <= S_DONE;
                                end else begin
                                    r_rsp   <= '{status: ST_OK, alloc_addr: '0,
                                                 free_count: '0};
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_rsp.alloc_addr <= alloc_addr;
                        r_state          <= S_DONE;
                    end else begin
                        if (r_rd_vld) begin
                            r_acc <= r_acc + 17'(zero_count(rd_data));
                        end
                        if (!r_rd_vld && (r_issue >= r_hi)) begin
                            if (r_op == REQ_ALLOC) begin
                                r_rsp.status <= ST_NONE;
                            end else begin
                                r_rsp.free_count <= sat_count;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE) && i_res_ready;
    assign o_rsp  = r_rsp;

    `PFBA_ASSERT_SAME(a_scan_bound, r_state == S_SCAN, r_issue <= r_hi,
                      "scan pointer passed zone end")
    `PFBA_ASSERT_SAME(a_alloc_sets_bit, wr_en && r_state == S_SCAN, wr_data != rd_data,
                      "alloc write left byte unchanged")
    `PFBA_ASSERT_NEXT(a_start_leaves_idle, r_state == S_IDLE && i_start, r_state != S_IDLE,
                      "request start did not leave idle")
    `PFBA_ASSERT_SAME(a_start_only_idle, i_start, o_idle,
                      "request started while engine busy")

endmodule

// ===== rtl/core/page_frame_bitmap_allocator.sv =====
// Alloc scans the zone bytes from its low end through the first byte with a free frame and sets
// that frame's bit; with no free frame it scans every zone byte, as count does.
// Free and reserve do a read, modify and write back of one bit; range errors and empty
// zones answer without touching the bitmap. The scan issues one bitmap RAM read per cycle.
// One request is in progress at a time; the next is taken the cycle after a result is registered.
// After reset the bitmap RAM is cleared byte by byte over all MAX_BITMAP_BYTES bytes, and requests stall meanwhile.
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// Top level with configuration registers, request intake and result register.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator #(
    parameter int          MAX_BITMAP_BYTES = 4096,
    parameter int          PAGE_SHIFT       = 12,
    parameter logic [31:0] FRAME_BASE       = 32'h0010_0000
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pfba_pkg::t_req                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pfba_pkg::t_rsp                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfba_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import pfba_pkg::*;

    logic [CFG_W-1:0] r_bitmap_bytes;
    logic [CFG_W-1:0] r_kernel_bytes;
    logic             r_out_vld;
    t_rsp             r_out_data;

    logic [CFG_W-1:0] eff_bytes;
    logic [CFG_W-1:0] split;
    logic             eng_idle;
    logic             eng_done;
    t_rsp             eng_rsp;
    logic             start;
    logic             res_ready;

    always_comb begin
        eff_bytes = (32'(r_bitmap_bytes) > 32'(MAX_BITMAP_BYTES)) ? CFG_W'(MAX_BITMAP_BYTES)
                                                                  : r_bitmap_bytes;
        split     = (r_kernel_bytes < eff_bytes) ? r_kernel_bytes : eff_bytes;
        start     = i_in_valid && eng_idle;
        res_ready = !r_out_vld || !i_out_stall;
    end

    pfba_engine #(
        .MAX_BITMAP_BYTES (MAX_BITMAP_BYTES),
        .PAGE_SHIFT       (PAGE_SHIFT),
        .FRAME_BASE       (FRAME_BASE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_in_data),
        .i_eff_bytes (eff_bytes),
        .i_split     (split),
        .i_res_ready (res_ready),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_rsp       (eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap_bytes <= BITMAP_BYTES_RST;
            r_kernel_bytes <= KERNEL_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_BITMAP: r_bitmap_bytes <= i_cfg_wdata;
                CFG_IDX_KERNEL: r_kernel_bytes <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (eng_done) begin
            r_out_vld  <= 1'b1;
            r_out_data <= eng_rsp;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_in_stall  = !eng_idle;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// ===== sim/pfba_checker.sv =====
// ----------------------------------------------------------------------------
// Page frame bitmap allocator checker
// Watches the request, result and register ports of the allocator, keeps its
// own copy of the frame bitmap and zone registers, predicts one result per
// accepted request and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module pfba_checker #(
    parameter int          MAX_BITMAP_BYTES = 4096,
    parameter int          PAGE_SHIFT       = 12,
    parameter logic [31:0] FRAME_BASE       = 32'h0010_0000
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  pfba_pkg::t_req                 i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  pfba_pkg::t_rsp                 i_out_data,
    input  logic                           i_cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfba_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pfba_pkg::*;

    logic [7:0]       frame_map [MAX_BITMAP_BYTES];
    logic [CFG_W-1:0] map_bytes    = BITMAP_BYTES_RST;
    logic [CFG_W-1:0] kernel_bytes = KERNEL_BYTES_RST;
    t_rsp             expected_rsp [$];
    int               fail_total    = 0;
    int               pending_total = 0;
    int               checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    task automatic apply_request(input t_req r, output t_rsp rsp);
        int unsigned end_b;
        int unsigned split;
        int unsigned lo;
        int unsigned hi;
        int unsigned nbits;
        int unsigned idx;
        int unsigned p;
        int unsigned b;
        int unsigned cnt;
        bit          found;
        end_b = (map_bytes > MAX_BITMAP_BYTES) ? MAX_BITMAP_BYTES : map_bytes;
        split = (kernel_bytes < end_b) ? kernel_bytes : end_b;
        lo    = (r.zone == ZONE_KERNEL) ? 0 : split;
        hi    = (r.zone == ZONE_KERNEL) ? split : end_b;
        nbits = end_b * 8;
        rsp   = '0;
        rsp.status = ST_OK;
        case (r.req_type)
            REQ_ALLOC: begin
                rsp.status = ST_NONE;
                found = 1'b0;
                for (p = lo; p < hi && !found; p++) begin
                    if (frame_map[p] != 8'hFF) begin
                        for (b = 0; b < 8; b++) begin
                            if (!frame_map[p][3'(7 - b)]) break;
                        end
                        frame_map[p][3'(7 - b)] = 1'b1;
                        rsp.alloc_addr = FRAME_BASE + ((p * 8 + b) << PAGE_SHIFT);
                        rsp.status = ST_OK;
                        found = 1'b1;
                    end
                end
            end
            REQ_FREE: begin
                if (r.frame_addr < FRAME_BASE) begin
                    rsp.status = ST_RANGE;
                end else begin
                    idx = (r.frame_addr - FRAME_BASE) >> PAGE_SHIFT;
                    if (idx >= nbits) rsp.status = ST_RANGE;
                    else frame_map[idx >> 3][3'(7 - (idx & 7))] = 1'b0;
                end
            end
            REQ_RESERVE: begin
                idx = r.frame_index;
                if (idx >= nbits) rsp.status = ST_RANGE;
                else frame_map[idx >> 3][3'(7 - (idx & 7))] = 1'b1;
            end
            REQ_COUNT: begin
                cnt = 0;
                for (p = lo; p < hi; p++) cnt += $countones(~frame_map[p]);
                rsp.free_count = (cnt > 32'hFFFF) ? 16'hFFFF : 16'(cnt);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            foreach (frame_map[k]) frame_map[k] = '0;
            map_bytes    = BITMAP_BYTES_RST;
            kernel_bytes = KERNEL_BYTES_RST;
            expected_rsp.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (expected_rsp.size() == 0) begin
                    $error("Result transaction arrived with no request outstanding.");
                    fail_total++;
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    if (i_out_data.status !== exp_rsp.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_rsp.status, i_out_data.status);
                        fail_total++;
                    end
                    if (i_out_data.alloc_addr !== exp_rsp.alloc_addr) begin
                        $error("alloc_addr: expected 0x%08h, actual 0x%08h",
                               exp_rsp.alloc_addr, i_out_data.alloc_addr);
                        fail_total++;
                    end
                    if (i_out_data.free_count !== exp_rsp.free_count) begin
                        $error("free_count: expected %0d, actual %0d",
                               exp_rsp.free_count, i_out_data.free_count);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_in_data, exp_rsp);
                expected_rsp.push_back(exp_rsp);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_BITMAP) map_bytes = i_cfg_wdata;
                else if (i_cfg_idx == CFG_IDX_KERNEL) kernel_bytes = i_cfg_wdata;
            end
        end
        pending_total = expected_rsp.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Page frame bitmap allocator testbench
// Drives directed and random alloc, free, reserve and count transactions
// through a series of zone settings, with random gaps on both channels and
// one long result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pfba_pkg::*;

    localparam int          MAX_BYTES   = 4096;
    localparam int          PG_SHIFT    = 12;
    localparam logic [31:0] BASE        = 32'h0010_0000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_PHASES = 16;
    localparam int          PHASE_ITEMS = 50;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    t_req                 req_data  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    t_rsp                 rsp_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_IDX_BITMAP;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned cur_bytes = 4096;
    int          sent      = 0;
    int          settings  = 1;
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;
    bit          hold_req  = 1'b0;

    always #5 clk = ~clk;

    page_frame_bitmap_allocator #(
        .MAX_BITMAP_BYTES(MAX_BYTES),
        .PAGE_SHIFT      (PG_SHIFT),
        .FRAME_BASE      (BASE)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_data  (req_data),
        .o_out_valid(rsp_valid),
        .i_out_stall(rsp_stall),
        .o_out_data (rsp_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    pfba_checker #(
        .MAX_BITMAP_BYTES(MAX_BYTES),
        .PAGE_SHIFT      (PG_SHIFT),
        .FRAME_BASE      (BASE)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_stall  (req_stall),
        .i_in_data   (req_data),
        .i_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .i_out_data  (rsp_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    function automatic t_req make_req(logic [1:0] kind, logic zone, logic [31:0] addr,
                                      logic [14:0] index);
        t_req r;
        r.req_type    = kind;
        r.zone        = zone;
        r.frame_addr  = addr;
        r.frame_index = index;
        return r;
    endfunction

    function automatic t_req random_req(int unsigned alloc_pct, int unsigned count_pct);
        t_req        r;
        int unsigned nbits;
        int unsigned pick;
        int unsigned sub;
        int unsigned idx;
        nbits         = ((cur_bytes > MAX_BYTES) ? MAX_BYTES : cur_bytes) * 8;
        r.zone        = 1'($urandom_range(0, 1));
        r.frame_addr  = $urandom();
        r.frame_index = 15'($urandom());
        pick          = $urandom_range(0, 99);
        sub           = $urandom_range(0, 9);
        idx           = $urandom_range(0, nbits + 1);
        if (pick < alloc_pct) begin
            r.req_type = REQ_ALLOC;
        end else if (pick < alloc_pct + count_pct) begin
            r.req_type = REQ_COUNT;
        end else if ($urandom_range(0, 1) == 0) begin
            r.req_type = REQ_FREE;
            if (sub < 7)
                r.frame_addr = BASE + (idx << PG_SHIFT) + ((sub == 0) ? $urandom_range(0, 4095) : 0);
            else if (sub == 7)
                r.frame_addr = $urandom_range(0, BASE - 1);
        end else begin
            r.req_type = REQ_RESERVE;
            if (sub < 8) r.frame_index = 15'(idx);
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic next_setting(input int unsigned bytes, input int unsigned kernel);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_IDX_BITMAP;
        cfg_wdata <= CFG_W'(bytes);
        @(negedge clk);
        cfg_idx   <= CFG_IDX_KERNEL;
        cfg_wdata <= CFG_W'(kernel);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_bytes = bytes;
        settings++;
    endtask

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding.", pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned gap;
        bit          held;
        held = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else begin
                gap = rx_calm ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                rsp_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    initial begin
        int unsigned bytes;
        int unsigned kernel;
        int unsigned alloc_pct;
        int unsigned count_pct;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        send_req(make_req(REQ_COUNT,   ZONE_KERNEL, 32'h0, 15'h0));
        send_req(make_req(REQ_COUNT,   ZONE_USER,   32'h0, 15'h0));
        send_req(make_req(REQ_ALLOC,   ZONE_KERNEL, 32'h0, 15'h0));
        send_req(make_req(REQ_ALLOC,   ZONE_USER,   32'hFFFF_FFFF, 15'h7FFF));
        send_req(make_req(REQ_RESERVE, ZONE_KERNEL, 32'h0, 15'd1));
        send_req(make_req(REQ_ALLOC,   ZONE_KERNEL, 32'h0, 15'h0));
        send_req(make_req(REQ_FREE,    ZONE_KERNEL, BASE, 15'h0));
        send_req(make_req(REQ_FREE,    ZONE_USER,   BASE, 15'h0));
        send_req(make_req(REQ_RESERVE, ZONE_USER,   32'h0, 15'd1));
        send_req(make_req(REQ_FREE,    ZONE_KERNEL, BASE - 1, 15'h0));
        send_req(make_req(REQ_FREE,    ZONE_KERNEL, 32'hFFFF_FFFF, 15'h0));
        send_req(make_req(REQ_FREE,    ZONE_KERNEL, BASE + 32'h2FFF, 15'h0));
        send_req(make_req(REQ_RESERVE, ZONE_KERNEL, 32'h0, 15'h7FFF));

        next_setting(1, 1);
        send_req(make_req(REQ_ALLOC,   ZONE_USER,   32'h0, 15'h0));
        send_req(make_req(REQ_COUNT,   ZONE_USER,   32'h0, 15'h0));
        send_req(make_req(REQ_RESERVE, ZONE_KERNEL, 32'h0, 15'd8));
        send_req(make_req(REQ_FREE,    ZONE_KERNEL, BASE + (8 << PG_SHIFT), 15'h0));

        next_setting(8191, 8191);
        send_req(make_req(REQ_COUNT,   ZONE_USER,   32'h0, 15'h0));
        send_req(make_req(REQ_ALLOC,   ZONE_USER,   32'h0, 15'h0));
        send_req(make_req(REQ_COUNT,   ZONE_KERNEL, 32'h0, 15'h0));
        send_req(make_req(REQ_RESERVE, ZONE_KERNEL, 32'h0, 15'h7FFF));

        next_setting(0, 0);
        send_req(make_req(REQ_ALLOC,   ZONE_KERNEL, 32'h0, 15'h0));
        send_req(make_req(REQ_FREE,    ZONE_KERNEL, BASE, 15'h0));
        send_req(make_req(REQ_RESERVE, ZONE_KERNEL, 32'h0, 15'h0));
        send_req(make_req(REQ_COUNT,   ZONE_KERNEL, 32'h0, 15'h0));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph % 6 == 5) begin
                bytes     = ($urandom_range(0, 1) == 0) ? MAX_BYTES : $urandom_range(2048, 8191);
                kernel    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(0, 200);
                count_pct = 3;
            end else begin
                bytes     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                kernel    = $urandom_range(0, bytes + 2);
                count_pct = 15;
            end
            alloc_pct = ph[0] ? 60 : 35;
            next_setting(bytes, kernel);
            tx_calm  = ($urandom_range(0, 3) == 0);
            rx_calm  = ($urandom_range(0, 3) == 0);
            hold_req = (ph == 1);
            repeat (PHASE_ITEMS) send_req(random_req(alloc_pct, count_pct));
        end

        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Sent %0d requests over %0d zone settings, empty and oversized zones included.",
                 sent, settings);
        $display("Checked %0d results, one of them after a %0d cycle result hold-off.",
                 checked, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
